FILE: rtl/core/fcr_pkg.sv
// Shared types and constants for the framed command receiver.
// Holds the request and result payload structs, the parser phase enum and codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcr_pkg;

  localparam int unsigned LimitWidth = 25;
  localparam int unsigned CodeWidth  = 17;

  localparam logic [7:0]            HeaderByte        = 8'h7E;
  localparam logic [LimitWidth-1:0] TimeoutLimitReset = 25'd25000000;

  // Result kinds
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindAccept  = 2'd1;
  localparam logic [1:0] KindError   = 2'd2;

  // Error kinds
  localparam logic [1:0] ErrHeader  = 2'd0;
  localparam logic [1:0] ErrTimeout = 2'd1;
  localparam logic [1:0] ErrSum     = 2'd2;

  // Positional error codes
  localparam logic [CodeWidth-1:0] CodeHeader  = 17'd1;
  localparam logic [CodeWidth-1:0] CodeCommand = 17'd2;
  localparam logic [CodeWidth-1:0] CodeAddress = 17'd3;
  localparam logic [CodeWidth-1:0] CodeLength  = 17'd4;
  localparam logic [CodeWidth-1:0] CodeSumBase = 17'd5;

  typedef enum logic [3:0] {
    PhHead  = 4'd0,
    PhCmd   = 4'd1,
    PhAddr0 = 4'd2,
    PhAddr1 = 4'd3,
    PhAddr2 = 4'd4,
    PhLen0  = 4'd5,
    PhLen1  = 4'd6,
    PhData  = 4'd7,
    PhSum   = 4'd8
  } phase_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } fcr_in_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           payload_byte;
    logic [15:0]          payload_index;
    logic [7:0]           command;
    logic [23:0]          address;
    logic [15:0]          length;
    logic [1:0]           error_kind;
    logic [CodeWidth-1:0] error_code;
    logic [7:0]           error_byte;
  } fcr_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/framed_command_receiver.sv
// Top level of the framed command receiver: input register, frame parser,
// result register and the timeout limit register. Depends on fcr_pkg and the fcr_* stages.
//
// Usage:
//   in channel   : one request per transfer; func=0 carries a received byte,
//                  func=1 is one timer tick. Frame: 0x7E, command, address
//                  (3 bytes, MSB first), length (2 bytes, MSB first),
//                  payload, 8-bit sum of everything after the header byte.
//   out channel  : zero or one result per request: a payload byte with its
//                  index, a frame accept with command/address/length, or an
//                  error (bad header, timeout, checksum mismatch).
//   cfg channel  : writes timeout_limit; always ready. Write only while idle.
//   Path         : a result passes the input register, which loads on accept,
//                  and then the result register, which loads when it has room.
//   Throughput   : one request per cycle while out_ready is high; the parser
//                  state update is combinational.
//   Reset        : parser returns to header search, counters clear and
//                  timeout_limit loads 25000000.
//   Stall        : when out_ready is low the result holds, one more request
//                  is buffered, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module framed_command_receiver (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire fcr_pkg::fcr_in_t               in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output fcr_pkg::fcr_out_t                   out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [fcr_pkg::LimitWidth-1:0] cfg_data
);

  logic                           take;
  logic                           hold_valid;
  fcr_pkg::fcr_in_t               hold_data;
  logic                           advance;
  logic                           res_valid;
  fcr_pkg::fcr_out_t              res_data;
  logic [fcr_pkg::LimitWidth-1:0] timeout_limit;

  assign cfg_ready = 1'b1;
  assign advance   = hold_valid && take;

  // Timeout limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= fcr_pkg::TimeoutLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      timeout_limit <= cfg_data;
    end
  end

  fcr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_data  (hold_data)
  );

  fcr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .item          (hold_data),
    .timeout_limit (timeout_limit),
    .res_valid     (res_valid),
    .result        (res_data)
  );

  fcr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res_valid),
    .res_data  (res_data),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> hold_valid && out_valid && !out_ready)
    else $error("input stalled without a blocked result");

  a_no_lost_result: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid |=> out_valid)
    else $error("result produced but not registered");

endmodule

`default_nettype wire

FILE: rtl/core/fcr_in_stage.sv
// Input register of the framed command receiver.
// Holds one request until the parser consumes it; uses fcr_pkg types.
`timescale 1ns / 1ps
`default_nettype none

module fcr_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire fcr_pkg::fcr_in_t in_data,
  input  wire logic            take,
  output logic                 hold_valid,
  output fcr_pkg::fcr_in_t     hold_data
);

  // Accept when empty or when the held request leaves this cycle
  assign in_ready = !hold_valid || take;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_data <= in_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fcr_parser.sv
// Frame parser state and per-request decode for the framed command receiver.
// Updates phase, header fields, running sum and idle tick count; uses fcr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fcr_parser (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            advance,
  input  wire fcr_pkg::fcr_in_t                item,
  input  wire logic [fcr_pkg::LimitWidth-1:0]  timeout_limit,
  output logic                                 res_valid,
  output fcr_pkg::fcr_out_t                    result
);

  fcr_pkg::phase_t                 phase, phase_next;
  logic [7:0]                      cmd_reg, cmd_reg_next;
  logic [23:0]                     addr_reg, addr_reg_next;
  logic [15:0]                     len_reg, len_reg_next;
  logic [15:0]                     byte_index, byte_index_next;
  logic [7:0]                      running_sum, running_sum_next;
  logic [fcr_pkg::LimitWidth-1:0]  idle_ticks, idle_ticks_next;

  logic [fcr_pkg::LimitWidth-1:0]  tick_count;
  logic                            timed_out;
  logic [7:0]                      sum_add;
  logic [15:0]                     index_inc;
  logic [15:0]                     len_full;
  logic [fcr_pkg::CodeWidth-1:0]   timeout_code;

  assign tick_count = idle_ticks + {{(fcr_pkg::LimitWidth-1){1'b0}}, 1'b1};
  assign timed_out  = (tick_count >= timeout_limit) || (tick_count == '0);
  assign sum_add    = running_sum + item.rx_byte;
  assign index_inc  = byte_index + 16'd1;
  assign len_full   = {len_reg[15:8], item.rx_byte};

  // Next state
  always_comb begin
    phase_next       = phase;
    cmd_reg_next     = cmd_reg;
    addr_reg_next    = addr_reg;
    len_reg_next     = len_reg;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    idle_ticks_next  = idle_ticks;
    if (item.func) begin
      if (timed_out) begin
        phase_next      = fcr_pkg::PhHead;
        idle_ticks_next = '0;
      end else begin
        idle_ticks_next = tick_count;
      end
    end else begin
      idle_ticks_next = '0;
      unique case (phase)
        fcr_pkg::PhCmd: begin
          cmd_reg_next     = item.rx_byte;
          running_sum_next = item.rx_byte;
          phase_next       = fcr_pkg::PhAddr0;
        end
        fcr_pkg::PhAddr0: begin
          addr_reg_next    = {item.rx_byte, 16'h0000};
          running_sum_next = sum_add;
          phase_next       = fcr_pkg::PhAddr1;
        end
        fcr_pkg::PhAddr1: begin
          addr_reg_next    = {addr_reg[23:16], item.rx_byte, addr_reg[7:0]};
          running_sum_next = sum_add;
          phase_next       = fcr_pkg::PhAddr2;
        end
        fcr_pkg::PhAddr2: begin
          addr_reg_next    = {addr_reg[23:8], item.rx_byte};
          running_sum_next = sum_add;
          phase_next       = fcr_pkg::PhLen0;
        end
        fcr_pkg::PhLen0: begin
          len_reg_next     = {item.rx_byte, 8'h00};
          running_sum_next = sum_add;
          phase_next       = fcr_pkg::PhLen1;
        end
        fcr_pkg::PhLen1: begin
          len_reg_next     = len_full;
          running_sum_next = sum_add;
          byte_index_next  = '0;
          phase_next       = (len_full == '0) ? fcr_pkg::PhSum : fcr_pkg::PhData;
        end
        fcr_pkg::PhData: begin
          running_sum_next = sum_add;
          byte_index_next  = index_inc;
          if (index_inc >= len_reg) begin
            phase_next = fcr_pkg::PhSum;
          end
        end
        fcr_pkg::PhSum: begin
          phase_next = fcr_pkg::PhHead;
        end
        default: begin
          // waiting for header, and any unused phase code
          phase_next = (item.rx_byte == fcr_pkg::HeaderByte) ? fcr_pkg::PhCmd
                                                            : fcr_pkg::PhHead;
        end
      endcase
    end
  end

  // Position reported by a timeout
  always_comb begin
    unique case (phase)
      fcr_pkg::PhCmd:   timeout_code = fcr_pkg::CodeCommand;
      fcr_pkg::PhAddr0,
      fcr_pkg::PhAddr1,
      fcr_pkg::PhAddr2: timeout_code = fcr_pkg::CodeAddress;
      fcr_pkg::PhLen0,
      fcr_pkg::PhLen1:  timeout_code = fcr_pkg::CodeLength;
      fcr_pkg::PhData:  timeout_code = fcr_pkg::CodeLength + {1'b0, byte_index};
      fcr_pkg::PhSum:   timeout_code = fcr_pkg::CodeLength + {1'b0, len_reg};
      default:          timeout_code = fcr_pkg::CodeHeader;
    endcase
  end

  // Result for the current request
  always_comb begin
    res_valid = 1'b0;
    result    = '0;
    if (item.func) begin
      if (timed_out) begin
        res_valid         = 1'b1;
        result.kind       = fcr_pkg::KindError;
        result.error_kind = fcr_pkg::ErrTimeout;
        result.error_code = timeout_code;
      end
    end else begin
      unique case (phase)
        fcr_pkg::PhCmd, fcr_pkg::PhAddr0, fcr_pkg::PhAddr1, fcr_pkg::PhAddr2,
        fcr_pkg::PhLen0, fcr_pkg::PhLen1: begin
          res_valid = 1'b0;
        end
        fcr_pkg::PhData: begin
          res_valid            = 1'b1;
          result.kind          = fcr_pkg::KindPayload;
          result.payload_byte  = item.rx_byte;
          result.payload_index = byte_index;
        end
        fcr_pkg::PhSum: begin
          res_valid = 1'b1;
          if (item.rx_byte == running_sum) begin
            result.kind    = fcr_pkg::KindAccept;
            result.command = cmd_reg;
            result.address = addr_reg;
            result.length  = len_reg;
          end else begin
            result.kind       = fcr_pkg::KindError;
            result.error_kind = fcr_pkg::ErrSum;
            result.error_code = fcr_pkg::CodeSumBase + {1'b0, len_reg};
            result.error_byte = running_sum;
          end
        end
        default: begin
          if (item.rx_byte != fcr_pkg::HeaderByte) begin
            res_valid         = 1'b1;
            result.kind       = fcr_pkg::KindError;
            result.error_kind = fcr_pkg::ErrHeader;
            result.error_code = fcr_pkg::CodeHeader;
            result.error_byte = item.rx_byte;
          end
        end
      endcase
    end
  end

  // Advance parser state on each consumed request
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= fcr_pkg::PhHead;
      cmd_reg     <= '0;
      addr_reg    <= '0;
      len_reg     <= '0;
      byte_index  <= '0;
      running_sum <= '0;
      idle_ticks  <= '0;
    end else if (advance) begin
      phase       <= phase_next;
      cmd_reg     <= cmd_reg_next;
      addr_reg    <= addr_reg_next;
      len_reg     <= len_reg_next;
      byte_index  <= byte_index_next;
      running_sum <= running_sum_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

  a_accept_from_sum: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && result.kind == fcr_pkg::KindAccept |-> phase == fcr_pkg::PhSum)
    else $error("frame accepted outside the checksum phase");

  a_payload_from_data: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && result.kind == fcr_pkg::KindPayload |-> phase == fcr_pkg::PhData)
    else $error("payload byte reported outside the data phase");

  a_error_returns_head: assert property (@(posedge clk) disable iff (rst)
    advance && res_valid && result.kind == fcr_pkg::KindError
    |=> phase == fcr_pkg::PhHead && idle_ticks == '0)
    else $error("parser did not return to header search after an error");

  a_tick_only_errors: assert property (@(posedge clk) disable iff (rst)
    advance && item.func && res_valid |-> result.kind == fcr_pkg::KindError)
    else $error("tick produced a non-error result");

endmodule

`default_nettype wire

FILE: rtl/core/fcr_out_stage.sv
// Result register of the framed command receiver.
// Holds one result until the receiver takes it; uses fcr_pkg types.
`timescale 1ns / 1ps
`default_nettype none

module fcr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire fcr_pkg::fcr_out_t res_data,
  output logic                  take,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output fcr_pkg::fcr_out_t     out_data
);

  // Room for a new result when empty or when the current one drains
  assign take = !out_valid || out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load;
    end
  end

  // Load the payload
  always_ff @(posedge clk) begin
    if (take && load) begin
      out_data <= res_data;
    end
  end

endmodule

`default_nettype wire
